// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the top-level rtl file
// both macros expect clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ADM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adm implication check failed");

// condition must never be true
`define ADM_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("adm forbidden condition seen");

`endif

// ----- hw/rtl/adm_pkg.sv -----
// ----------------------------------------------------------------------------
// adm_pkg
// Shared constants, codes and pipeline payload types of the arcade drive
// mixer with dither braking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adm_pkg;

  localparam int SampleW  = 16;
  localparam int FracW    = SampleW - 1;
  localparam int PwrW     = SampleW + 1;
  localparam int MagW     = SampleW;
  localparam int RemW     = MagW + 1;
  localparam int AmtW     = 4;
  localparam int NumW     = MagW + AmtW;
  localparam int DivSteps = FracW;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  localparam logic [AmtW-1:0]  MaxBrakeReset = AmtW'(8);
  localparam logic [FracW-1:0] ThrReset      = FracW'(((1 << FracW) * 10) / 128);
  localparam logic [FracW-1:0] DeadbandReset = FracW'(((1 << FracW) * 25) / 128);

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_COAST = 2'd1,
    ACT_BRAKE = 2'd2
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SQUARED     = 4'd0,
    REG_MAX_BRAKING = 4'd1,
    REG_TIP_THRESH  = 4'd2,
    REG_DEADBAND    = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             squared;
    logic [AmtW-1:0]  max_braking;
    logic [FracW-1:0] tip_thr;
    logic [FracW-1:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic signed [PwrW-1:0] fwd;
    logic signed [PwrW-1:0] left;
    logic signed [PwrW-1:0] right;
    logic                   tip;
    logic                   inb_left;
    logic                   scale;
    logic                   sat;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [FracW-1:0] sh;
    logic [FracW-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t sc;
    lane_t br;
    side_t side;
  } div_t;

endpackage

`default_nettype wire

// ----- hw/rtl/adm_front.sv -----
// ----------------------------------------------------------------------------
// adm_front
// Two pipeline stages: optional sign-keeping squaring, then mixing,
// region decode and setup of the scaling and braking dividends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adm_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  adm_pkg::cfg_t                         cfg_i,
  input  wire            [adm_pkg::MagW-1:0]    brk_div_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire signed     [adm_pkg::SampleW-1:0] forward_cmd_i,
  input  wire signed     [adm_pkg::SampleW-1:0] turn_cmd_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output adm_pkg::div_t                         out_o
);
  import adm_pkg::*;

  // stage 1: magnitudes, optionally squared
  logic              s1_valid_q, s1_ready;
  logic [MagW-1:0]   s1_mf_q, s1_mt_q;
  logic              s1_nf_q, s1_nt_q;
  logic [MagW-1:0]   mf_abs, mt_abs;
  logic [2*MagW-1:0] mf_prod, mt_prod;
  logic [MagW-1:0]   s1_mf_d, s1_mt_d;

  assign mf_abs  = ({MagW{forward_cmd_i[SampleW-1]}} ^ forward_cmd_i)
                 + MagW'(forward_cmd_i[SampleW-1]);
  assign mt_abs  = ({MagW{turn_cmd_i[SampleW-1]}} ^ turn_cmd_i)
                 + MagW'(turn_cmd_i[SampleW-1]);
  assign mf_prod = mf_abs * mf_abs;
  assign mt_prod = mt_abs * mt_abs;
  assign s1_mf_d = cfg_i.squared ? mf_prod[FracW+MagW-1:FracW] : mf_abs;
  assign s1_mt_d = cfg_i.squared ? mt_prod[FracW+MagW-1:FracW] : mt_abs;

  // stage 2
  logic s2_valid_q, s2_ready;
  div_t s2_q, s2_d;

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_mf_q <= s1_mf_d;
      s1_mt_q <= s1_mt_d;
      s1_nf_q <= forward_cmd_i[SampleW-1];
      s1_nt_q <= turn_cmd_i[SampleW-1];
    end
  end

  logic                   negf, negt;
  logic signed [PwrW-1:0] fwd_pos, trn_pos, fwd, trn;
  logic [2*MagW-1:0]      prod_sc;
  logic [MagW-1:0]        diff;
  logic [AmtW:0]          maxp1;
  logic [NumW-1:0]        num;

  // a squared value of zero has no sign
  assign negf    = s1_nf_q && (|s1_mf_q);
  assign negt    = s1_nt_q && (|s1_mt_q);
  assign fwd_pos = $signed({1'b0, s1_mf_q});
  assign trn_pos = $signed({1'b0, s1_mt_q});
  assign fwd     = negf ? -fwd_pos : fwd_pos;
  assign trn     = negt ? -trn_pos : trn_pos;
  assign prod_sc = s1_mf_q * s1_mt_q;
  assign diff    = s1_mt_q - {1'b0, cfg_i.deadband};
  assign maxp1   = {1'b0, cfg_i.max_braking} + (AmtW+1)'(1);
  assign num     = NumW'(diff) * NumW'(maxp1);

  always_comb begin
    s2_d.side.fwd      = fwd;
    s2_d.side.tip      = s1_mf_q < {1'b0, cfg_i.tip_thr};
    s2_d.side.scale    = s1_mt_q < {1'b0, cfg_i.deadband};
    s2_d.side.inb_left = negt ? negf : !negf;
    // quotient of sixteen or more always saturates
    s2_d.side.sat      = num[NumW-1:AmtW] >= brk_div_i;
    if (s2_d.side.tip) begin
      s2_d.side.left  = -trn;
      s2_d.side.right = trn;
    end else begin
      s2_d.side.left  = fwd - trn;
      s2_d.side.right = fwd + trn;
    end
    // scaling quotient is known below 2^FracW, so the top half starts the remainder
    s2_d.sc.rem = RemW'(prod_sc[2*MagW-2:FracW]);
    s2_d.sc.sh  = prod_sc[FracW-1:0];
    s2_d.sc.quo = '0;
    // brake dividend bits trail with zeros, the quotient lands in the top bits
    s2_d.br.rem = RemW'(num[NumW-1:AmtW]);
    s2_d.br.sh  = {num[AmtW-1:0], (FracW-AmtW)'(0)};
    s2_d.br.quo = '0;
  end

  assign s2_ready = !s2_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

`default_nettype wire

// ----- hw/rtl/adm_div_step.sv -----
// ----------------------------------------------------------------------------
// adm_div_step
// One restoring division step for the scaling lane and the braking lane,
// registered, with its own valid bit and the side data carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adm_div_step (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire           [adm_pkg::MagW-1:0] sc_div_i,
  input  wire           [adm_pkg::MagW-1:0] br_div_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  adm_pkg::div_t                     in_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output adm_pkg::div_t                     out_o
);
  import adm_pkg::*;

  function automatic lane_t div_step_f(lane_t l, logic [MagW-1:0] d);
    logic [RemW-1:0] r;
    logic            ge;
    lane_t           n;
    r       = {l.rem[RemW-2:0], l.sh[FracW-1]};
    ge      = r >= {1'b0, d};
    n.rem   = ge ? r - {1'b0, d} : r;
    n.sh    = {l.sh[FracW-2:0], 1'b0};
    n.quo   = {l.quo[FracW-2:0], ge};
    return n;
  endfunction

  logic valid_q;
  div_t data_q, data_d;

  always_comb begin
    data_d      = in_i;
    data_d.sc   = div_step_f(in_i.sc, sc_div_i);
    data_d.br   = div_step_f(in_i.br, br_div_i);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/adm_back.sv -----
// ----------------------------------------------------------------------------
// adm_back
// Output stage: applies the scaled inboard power, the saturated brake amount
// or coasting for turn in place, and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adm_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire         [adm_pkg::AmtW-1:0]     max_braking_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  adm_pkg::div_t                       in_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [adm_pkg::PwrW-1:0]     left_power_o,
  output logic signed [adm_pkg::PwrW-1:0]     right_power_o,
  output logic        [1:0]                   left_action_o,
  output logic        [1:0]                   right_action_o,
  output logic        [adm_pkg::AmtW-1:0]     brake_amount_o
);
  import adm_pkg::*;

  logic                   valid_q;
  logic signed [PwrW-1:0] left_q, left_d, right_q, right_d;
  act_e                   lact_q, lact_d, ract_q, ract_d;
  logic [AmtW-1:0]        amt_q, amt_d;

  logic signed [PwrW-1:0] q_sc, p;
  logic [AmtW-1:0]        q_br, brk;

  // fwd minus the quotient carrying the sign of fwd, i.e. truncation toward zero
  assign q_sc = in_i.side.fwd[PwrW-1] ? -$signed(PwrW'(in_i.sc.quo))
                                      : $signed(PwrW'(in_i.sc.quo));
  assign p    = in_i.side.fwd - q_sc;
  assign q_br = in_i.br.quo[FracW-1:FracW-AmtW];
  assign brk  = (in_i.side.sat || (q_br > max_braking_i)) ? max_braking_i : q_br;

  always_comb begin
    left_d  = in_i.side.left;
    right_d = in_i.side.right;
    lact_d  = ACT_NONE;
    ract_d  = ACT_NONE;
    amt_d   = '0;
    if (in_i.side.tip) begin
      lact_d = ACT_COAST;
      ract_d = ACT_COAST;
    end else if (in_i.side.scale) begin
      if (in_i.side.inb_left) begin
        left_d = p;
      end else begin
        right_d = p;
      end
    end else begin
      amt_d = brk;
      if (in_i.side.inb_left) begin
        left_d = '0;
        lact_d = ACT_BRAKE;
      end else begin
        right_d = '0;
        ract_d  = ACT_BRAKE;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      lact_q  <= lact_d;
      ract_q  <= ract_d;
      amt_q   <= amt_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign left_power_o   = left_q;
  assign right_power_o  = right_q;
  assign left_action_o  = lact_q;
  assign right_action_o = ract_q;
  assign brake_amount_o = amt_q;

endmodule

`default_nettype wire

// ----- hw/rtl/arcade_drive_dither_brake_mixer.sv -----
// ----------------------------------------------------------------------------
// arcade_drive_dither_brake_mixer
// Arcade drive mixer with dither braking: forward and turn commands in,
// left and right powers with per-side coast or brake commands out.
// ----------------------------------------------------------------------------
// Takes one forward/turn request per clock unless the output stalls, and passes
// it through two stages of squaring and mixing, fifteen restoring division steps
// (one quotient bit each, the scaling and braking divisions side by side),
// and a registered output stage. Every stage has its own valid bit and
// passes ready upstream, so a stalled output fills the pipeline without
// losing requests and empty slots close up. Configuration registers (index
// 0 squared inputs, 1 max braking, 2 turn in place threshold, 3 deadband)
// are written through the cfg channel, which is always ready; write them
// only while no request is in flight. Unknown indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module arcade_drive_dither_brake_mixer (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire            [adm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire            [adm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire signed     [adm_pkg::SampleW-1:0]   forward_cmd_i,
  input  wire signed     [adm_pkg::SampleW-1:0]   turn_cmd_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic signed    [adm_pkg::PwrW-1:0]      left_power_o,
  output logic signed    [adm_pkg::PwrW-1:0]      right_power_o,
  output logic           [1:0]                    left_action_o,
  output logic           [1:0]                    right_action_o,
  output logic           [adm_pkg::AmtW-1:0]      brake_amount_o
);
  import adm_pkg::*;

  cfg_t            cfg_q;
  logic [MagW-1:0] brk_div;
  logic [MagW-1:0] sc_div;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.squared     <= 1'b0;
      cfg_q.max_braking <= MaxBrakeReset;
      cfg_q.tip_thr     <= ThrReset;
      cfg_q.deadband    <= DeadbandReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_SQUARED:     cfg_q.squared     <= cfg_data_i[0];
        REG_MAX_BRAKING: cfg_q.max_braking <= cfg_data_i[AmtW-1:0];
        REG_TIP_THRESH:  cfg_q.tip_thr     <= cfg_data_i[FracW-1:0];
        REG_DEADBAND:    cfg_q.deadband    <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  // braking range below full scale, never zero
  assign brk_div = MagW'(1 << FracW) - MagW'(cfg_q.deadband);
  assign sc_div  = MagW'(cfg_q.deadband);

  div_t              div_pl [DivSteps+1];
  logic [DivSteps:0] div_v;
  logic [DivSteps:0] div_r;

  adm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .brk_div_i     (brk_div),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .forward_cmd_i (forward_cmd_i),
    .turn_cmd_i    (turn_cmd_i),
    .out_valid_o   (div_v[0]),
    .out_ready_i   (div_r[0]),
    .out_o         (div_pl[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    adm_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .sc_div_i    (sc_div),
      .br_div_i    (brk_div),
      .in_valid_i  (div_v[k]),
      .in_ready_o  (div_r[k]),
      .in_i        (div_pl[k]),
      .out_valid_o (div_v[k+1]),
      .out_ready_i (div_r[k+1]),
      .out_o       (div_pl[k+1])
    );
  end

  adm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_braking_i  (cfg_q.max_braking),
    .in_valid_i     (div_v[DivSteps]),
    .in_ready_o     (div_r[DivSteps]),
    .in_i           (div_pl[DivSteps]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_power_o   (left_power_o),
    .right_power_o  (right_power_o),
    .left_action_o  (left_action_o),
    .right_action_o (right_action_o),
    .brake_amount_o (brake_amount_o)
  );

  logic vld_lbrake, vld_rbrake, vld_lcoast, vld_amount;

  assign vld_lbrake = out_valid_o && (left_action_o == ACT_BRAKE);
  assign vld_rbrake = out_valid_o && (right_action_o == ACT_BRAKE);
  assign vld_lcoast = out_valid_o && (left_action_o == ACT_COAST);
  assign vld_amount = out_valid_o && (brake_amount_o != '0);

  `ADM_ASSERT_NEVER(a_one_side_brakes, vld_lbrake && vld_rbrake)
  `ADM_ASSERT_IMPL(a_coast_pairs, vld_lcoast, right_action_o == ACT_COAST)
  `ADM_ASSERT_IMPL(a_amount_needs_brake, vld_amount, vld_lbrake || vld_rbrake)
  `ADM_ASSERT_IMPL(a_spin_mirrors, vld_lcoast, left_power_o == -right_power_o)

endmodule

`default_nettype wire

// ----- tb/sv/arcade_drive_dither_brake_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// arcade_drive_dither_brake_mixer_tb
// Self-checking bench for the arcade drive mixer: feeds forward/turn requests
// from a backlog queue, predicts each result with a fixed-point mixing model
// and compares every returned result against the oldest prediction, across
// several register settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arcade_drive_dither_brake_mixer_tb;
  import adm_pkg::*;

  localparam longint One          = longint'(1) << FracW;
  localparam int     LongHold     = 300;
  localparam int     DrainCycles  = 40;
  localparam int     PhaseItems   = 125;
  localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(12);

  typedef struct packed {
    logic signed [SampleW-1:0] fwd;
    logic signed [SampleW-1:0] trn;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [PwrW-1:0] left_power;
    logic signed [PwrW-1:0] right_power;
    logic [1:0]             left_action;
    logic [1:0]             right_action;
    logic [AmtW-1:0]        brake_amount;
  } mix_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SampleW-1:0] forward_cmd_i = '0;
  logic signed [SampleW-1:0] turn_cmd_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [PwrW-1:0] left_power_o;
  logic signed [PwrW-1:0] right_power_o;
  logic [1:0] left_action_o;
  logic [1:0] right_action_o;
  logic [AmtW-1:0] brake_amount_o;

  // register copies used by the predictor
  logic             cfg_squared = 1'b0;
  logic [AmtW-1:0]  cfg_max_brake = MaxBrakeReset;
  logic [FracW-1:0] cfg_tip_thr = ThrReset;
  logic [FracW-1:0] cfg_deadband = DeadbandReset;

  drive_cmd_t  cmd_backlog[$];
  mix_result_t mix_pending[$];
  int          mismatch_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  arcade_drive_dither_brake_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .forward_cmd_i (forward_cmd_i),
    .turn_cmd_i    (turn_cmd_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_power_o  (left_power_o),
    .right_power_o (right_power_o),
    .left_action_o (left_action_o),
    .right_action_o(right_action_o),
    .brake_amount_o(brake_amount_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint square_signed(longint v);
    longint a;
    longint s;
    a = (v < 0) ? -v : v;
    s = (a * a) >>> FracW;
    return (v < 0) ? -s : s;
  endfunction

  function automatic mix_result_t mix_drive(logic signed [SampleW-1:0] fwd_in,
                                            logic signed [SampleW-1:0] trn_in);
    longint f, t, af, at, lp, rp, sc, q, b, thr, db, mb;
    logic inb_left;
    mix_result_t r;
    f = fwd_in;
    t = trn_in;
    thr = cfg_tip_thr;
    db = cfg_deadband;
    mb = cfg_max_brake;
    if (cfg_squared) begin
      f = square_signed(f);
      t = square_signed(t);
    end
    af = (f < 0) ? -f : f;
    at = (t < 0) ? -t : t;
    r.left_action = ACT_NONE;
    r.right_action = ACT_NONE;
    r.brake_amount = '0;
    if (af < thr) begin
      // turn in place
      lp = -t;
      rp = t;
      r.left_action = ACT_COAST;
      r.right_action = ACT_COAST;
    end else begin
      lp = f - t;
      rp = f + t;
      inb_left = (t >= 0) ? (f >= 0) : (f < 0);
      if (at < db) begin
        sc = f * at;
        q = ((sc < 0) ? -sc : sc) / db;
        if (sc < 0) q = -q;
        if (inb_left) lp = f - q;
        else rp = f - q;
      end else begin
        b = (at - db) * (mb + 1) / (One - db);
        if (b > mb) b = mb;
        r.brake_amount = b[AmtW-1:0];
        if (inb_left) begin
          lp = 0;
          r.left_action = ACT_BRAKE;
        end else begin
          rp = 0;
          r.right_action = ACT_BRAKE;
        end
      end
    end
    r.left_power = lp[PwrW-1:0];
    r.right_power = rp[PwrW-1:0];
    return r;
  endfunction

  // full-range values half the time, else near a decision pivot, an extreme or small
  function automatic logic [SampleW-1:0] pick_sample(int pivot);
    int v;
    logic [SampleW-1:0] s;
    case ($urandom_range(5))
      3: begin
        v = pivot + $urandom_range(8) - 4;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        s = SampleW'(v);
        if ($urandom_range(1)) s = -s;
      end
      4: begin
        case ($urandom_range(4))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          2: s = 16'h0000;
          3: s = 16'h0001;
          default: s = 16'hffff;
        endcase
      end
      5: begin
        s = SampleW'($urandom_range(512));
        if ($urandom_range(1)) s = -s;
      end
      default: s = SampleW'($urandom);
    endcase
    return s;
  endfunction

  // sender: one request held on the port until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    drive_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      forward_cmd_i <= '0;
      turn_cmd_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) mix_pending.push_back(mix_drive(forward_cmd_i, turn_cmd_i));
      if (!(in_valid_i && !in_ready_o)) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          in_valid_i <= 1'b1;
          forward_cmd_i <= nxt.fwd;
          turn_cmd_i <= nxt.trn;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    mix_result_t got;
    mix_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{left_power_o, right_power_o, left_action_o, right_action_o, brake_amount_o};
      if (mix_pending.size() == 0) begin
        $display("%0t unexpected result: actual L=%0d R=%0d la=%0d ra=%0d amt=%0d", $time,
                 got.left_power, got.right_power, got.left_action, got.right_action,
                 got.brake_amount);
        mismatch_cnt++;
      end else begin
        want = mix_pending.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected L=%0d R=%0d la=%0d ra=%0d amt=%0d", $time,
                   want.left_power, want.right_power, want.left_action, want.right_action,
                   want.brake_amount);
          $display("%0t           actual   L=%0d R=%0d la=%0d ra=%0d amt=%0d", $time,
                   got.left_power, got.right_power, got.left_action, got.right_action,
                   got.brake_amount);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SQUARED:     cfg_squared = data[0];
      REG_MAX_BRAKING: cfg_max_brake = data[AmtW-1:0];
      REG_TIP_THRESH:  cfg_tip_thr = data[FracW-1:0];
      REG_DEADBAND:    cfg_deadband = data[FracW-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits get random junk
  task automatic set_regs(input logic sq, input int mb, input int thr, input int db);
    write_reg(REG_SQUARED, {CfgDataW'($urandom) & ~CfgDataW'(1)} | CfgDataW'(sq));
    write_reg(REG_MAX_BRAKING, {12'($urandom), 4'(mb)});
    write_reg(REG_TIP_THRESH, {1'($urandom), 15'(thr)});
    write_reg(REG_DEADBAND, {1'($urandom), 15'(db)});
  endtask

  task automatic queue_cmd(input logic [SampleW-1:0] f, input logic [SampleW-1:0] t);
    cmd_backlog.push_back('{f, t});
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_cmd(pick_sample(cfg_tip_thr), pick_sample(cfg_deadband));
  endtask

  task automatic wait_idle;
    do @(posedge clk_i);
    while (cmd_backlog.size() > 0 || in_valid_i || mix_pending.size() > 0);
  endtask

  task automatic run_phase(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    queue_random(n);
    wait_idle();
  endtask

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: extremes, threshold and deadband edges
    queue_cmd(16'sd0, 16'sd0);
    queue_cmd(16'sd32767, 16'sd0);
    queue_cmd(-16'sd32768, 16'sd0);
    queue_cmd(16'sd0, 16'sd32767);
    queue_cmd(16'sd0, -16'sd32768);
    queue_cmd(16'sd32767, 16'sd32767);
    queue_cmd(-16'sd32768, -16'sd32768);
    queue_cmd(16'sd32767, -16'sd32768);
    queue_cmd(-16'sd32768, 16'sd32767);
    queue_cmd(16'sd2559, 16'sd100);
    queue_cmd(16'sd2560, 16'sd100);
    queue_cmd(-16'sd2560, -16'sd100);
    queue_cmd(-16'sd2559, 16'sd3000);
    queue_cmd(16'sd20000, 16'sd6399);
    queue_cmd(16'sd20000, 16'sd6400);
    queue_cmd(-16'sd20000, -16'sd6400);
    queue_cmd(-16'sd20000, 16'sd6401);
    queue_cmd(16'sd20000, -16'sd1000);
    queue_cmd(-16'sd12345, 16'sd1000);
    queue_cmd(16'sd9000, 16'sd30000);
    run_phase(PhaseItems, 0, 0);

    // squared inputs, widest brake range, no turn in place, tiny deadband
    set_regs(1'b1, 15, 0, 1);
    queue_cmd(-16'sd32768, -16'sd32768);
    queue_cmd(16'sd32767, 16'sd181);
    queue_cmd(16'sd181, -16'sd182);
    run_phase(PhaseItems, 70, 0);

    // no braking amount, turn in place almost everywhere, widest deadband
    set_regs(1'b0, 0, 32767, 32767);
    queue_cmd(-16'sd32768, 16'sd32767);
    queue_cmd(-16'sd32768, -16'sd32768);
    run_phase(PhaseItems, 0, 70);

    // zero deadband: everything outside turn in place brakes
    set_regs(1'b0, 5, 1000, 0);
    write_reg(RegSpare, 16'hffff);
    queue_cmd(16'sd5000, 16'sd0);
    queue_cmd(-16'sd5000, 16'sd0);
    run_phase(PhaseItems, 9, 9);

    // long receiver hold-off while requests keep coming
    set_regs(1'b0, 8, 2560, 6400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(PhaseItems);
    repeat (5) @(posedge clk_i);
    hold_req++;
    wait_idle();

    // sender pauses halfway until everything has drained
    set_regs(1'b1, 12, 300, 20000);
    run_phase(PhaseItems / 2, 9, 9);
    run_phase(PhaseItems / 2, 0, 0);

    for (int k = 0; k < 3; k++) begin
      set_regs(1'($urandom), $urandom_range(15), $urandom_range(8000),
               $urandom_range(1, 32767));
      case (k)
        0: run_phase(PhaseItems, 70, 70);
        1: run_phase(PhaseItems, 70, 0);
        default: run_phase(PhaseItems, 0, 70);
      endcase
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && mix_pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
